FILE: rtl/secu_pkg.sv
`timescale 1ns / 1ps

package secu_pkg;

  // grid geometry
  localparam int GRID_SIDE_DEF = 64;
  localparam int COORD_W       = 6;

  // field widths
  localparam int DRAW_W    = 15;
  localparam int PROB_W    = 16;
  localparam int STATE_W   = 3;
  localparam int CNT_W     = 4;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int NB_IDX_W  = 3;
  localparam int ALU_W     = 17;

  localparam logic [CNT_W-1:0] NB_MAX = 4'd8;

  // cell states with a meaning of their own
  localparam logic [STATE_W-1:0] CELL_REST    = 3'd0;
  localparam logic [STATE_W-1:0] CELL_EXCITED = 3'd1;

  // operations
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EARLY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LATE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NCNT  = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RED_X,
    ST_RED_Y,
    ST_RD_C,
    ST_DEC,
    ST_NB,
    ST_NB_LAST,
    ST_THR,
    ST_WR
  } state_e;

  typedef struct packed {
    logic             lt;
    logic [ALU_W-1:0] diff;
  } alu_res_t;

  // neighbor offsets as offset + 1, order N,E,S,W,NE,SE,SW,NW
  function automatic logic [1:0] nb_dx(input logic [NB_IDX_W-1:0] i);
    logic [1:0] r;
    unique case (i)
      3'd0: r = 2'd1;
      3'd1: r = 2'd2;
      3'd2: r = 2'd1;
      3'd3: r = 2'd0;
      3'd4: r = 2'd2;
      3'd5: r = 2'd2;
      3'd6: r = 2'd0;
      3'd7: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nb_dy(input logic [NB_IDX_W-1:0] i);
    logic [1:0] r;
    unique case (i)
      3'd0: r = 2'd0;
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd3: r = 2'd1;
      3'd4: r = 2'd0;
      3'd5: r = 2'd2;
      3'd6: r = 2'd2;
      3'd7: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/secu_ram.sv
`timescale 1ns / 1ps

module secu_ram #(
  parameter int WIDTH = secu_pkg::STATE_W,
  parameter int DEPTH = secu_pkg::GRID_SIDE_DEF * secu_pkg::GRID_SIDE_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/secu_alu.sv
`timescale 1ns / 1ps

// shared subtract/compare unit
module secu_alu (
  input  logic [secu_pkg::ALU_W-1:0] a_i,
  input  logic [secu_pkg::ALU_W-1:0] b_i,
  output secu_pkg::alu_res_t         res_o
);

  import secu_pkg::*;

  logic [ALU_W:0] sub;

  assign sub        = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.lt   = sub[ALU_W];
  assign res_o.diff = sub[ALU_W-1:0];

endmodule

FILE: rtl/secu_addr.sv
`timescale 1ns / 1ps

// cell address of the center or of one neighbor, toroidal wrap
module secu_addr #(
  parameter int GRID_SIDE = secu_pkg::GRID_SIDE_DEF
) (
  input  logic [$clog2(GRID_SIDE)-1:0]             x_i,
  input  logic [$clog2(GRID_SIDE)-1:0]             y_i,
  input  logic                                     center_i,
  input  logic [secu_pkg::NB_IDX_W-1:0]            nb_idx_i,
  output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]   addr_o
);

  import secu_pkg::*;

  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);
  localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

  logic [1:0]    dx, dy;
  logic [CW-1:0] xm, xp, ym, yp, xs, ys;

  always_comb begin
    dx = center_i ? 2'd1 : nb_dx(nb_idx_i);
    dy = center_i ? 2'd1 : nb_dy(nb_idx_i);
    xm = (x_i == '0)   ? LAST : x_i - CW'(1);
    xp = (x_i == LAST) ? '0   : x_i + CW'(1);
    ym = (y_i == '0)   ? LAST : y_i - CW'(1);
    yp = (y_i == LAST) ? '0   : y_i + CW'(1);
    case (dx)
      2'd0:    xs = xm;
      2'd2:    xs = xp;
      default: xs = x_i;
    endcase
    case (dy)
      2'd0:    ys = ym;
      2'd2:    ys = yp;
      default: ys = y_i;
    endcase
    addr_o = AW'(xs) + AW'(ys) * AW'(GRID_SIDE);
  end

endmodule

FILE: rtl/stochastic_excitable_cell_update_unit.sv
`timescale 1ns / 1ps

// Stochastic excitable cell update unit (8-state Greenberg-Hastings grid).
// Input channel: an item is taken at a rising edge with start_i high and
// busy_o low. operation_i selects an update event or a direct cell write.
// Result channel: done_o pulses for one cycle with old_state_o, new_state_o,
// excited_neighbors_o and changed_o; the receiver cannot stall, so the
// result is simply presented once.
// Config port: cfg_we_i writes cfg_data_i to register cfg_index_i at once
// (0 birth, 1 early advance probs, 2 late advance probs, 3 threshold,
// 4 neighbor count); other indexes are dropped. Write only while idle.
// Flow: every item runs through one shared subtract/compare unit and the
// single-port grid RAM. Each coordinate is wrapped by repeated subtraction
// of GRID_SIDE, x first, then y. Then center read, decide, and write back.
// A resting cell whose birth draw passes adds n neighbor reads, one drain
// step and a threshold compare, or only the compare when no neighbor is
// examined. Writes, non-resting cells and failed birth draws skip these.
// done_o follows in the cycle after write back; busy_o drops in that same
// cycle, so the next item can be taken there.
// Reset: a clearing pass writes every cell to rest, with busy_o high;
// config writes are taken meanwhile.
module stochastic_excitable_cell_update_unit #(
  parameter int GRID_SIDE = secu_pkg::GRID_SIDE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config port
  input  logic                              cfg_we_i,
  input  logic [secu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [secu_pkg::CFG_W-1:0]        cfg_data_i,
  // item in
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              operation_i,
  input  logic [secu_pkg::COORD_W-1:0]      col_x_i,
  input  logic [secu_pkg::COORD_W-1:0]      row_y_i,
  input  logic [secu_pkg::DRAW_W-1:0]       uniform_draw_i,
  input  logic [secu_pkg::STATE_W-1:0]      write_value_i,
  // result out
  output logic                              done_o,
  output logic [secu_pkg::STATE_W-1:0]      old_state_o,
  output logic [secu_pkg::STATE_W-1:0]      new_state_o,
  output logic [secu_pkg::CNT_W-1:0]        excited_neighbors_o,
  output logic                              changed_o
);

  import secu_pkg::*;

  localparam int CW    = $clog2(GRID_SIDE);
  localparam int AW    = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  // coordinate register holds the raw input until it is wrapped
  localparam int XW    = (CW > COORD_W) ? CW : COORD_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

  // config registers
  logic [PROB_W-1:0]    birth_q;
  logic [4*PROB_W-1:0]  early_q;
  logic [3*PROB_W-1:0]  late_q;
  logic [CNT_W-1:0]     thr_q;
  logic [CNT_W-1:0]     ncnt_q;

  // control
  state_e               state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [NB_IDX_W-1:0]  nb_idx_q, nb_idx_d;
  logic                 pend_q, pend_d;
  logic                 done_q, done_d;

  // item payload
  logic                 op_q, op_d;
  logic [XW-1:0]        x_q, x_d, y_q, y_d;
  logic [DRAW_W-1:0]    draw_q, draw_d;
  logic [STATE_W-1:0]   wval_q, wval_d;
  logic [STATE_W-1:0]   old_q, old_d, nxt_q, nxt_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  // datapath
  logic [ALU_W-1:0]     alu_a, alu_b;
  alu_res_t             alu_res;
  logic                 addr_center;
  logic [AW-1:0]        gen_addr, ram_addr;
  logic                 ram_we;
  logic [STATE_W-1:0]   ram_wdata, ram_rdata;
  logic [PROB_W-1:0]    prob_sel;
  logic [CNT_W-1:0]     n_eff;

  // ---------------------------------------------------------------------
  // config
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q <= 16'h8000;
      early_q <= 64'h8000_8000_8000_8000;
      late_q  <= 48'h8000_8000_8000;
      thr_q   <= 4'd1;
      ncnt_q  <= 4'd4;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BIRTH: birth_q <= cfg_data_i[PROB_W-1:0];
        REG_EARLY: early_q <= cfg_data_i;
        REG_LATE:  late_q  <= cfg_data_i[3*PROB_W-1:0];
        REG_THR:   thr_q   <= cfg_data_i[CNT_W-1:0];
        REG_NCNT:  ncnt_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // neighbor count saturates at eight
  assign n_eff = (ncnt_q > NB_MAX) ? NB_MAX : ncnt_q;

  // advance probability of a nonresting state, birth for rest
  always_comb begin
    unique case (ram_rdata)
      3'd0: prob_sel = birth_q;
      3'd1: prob_sel = early_q[15:0];
      3'd2: prob_sel = early_q[31:16];
      3'd3: prob_sel = early_q[47:32];
      3'd4: prob_sel = early_q[63:48];
      3'd5: prob_sel = late_q[15:0];
      3'd6: prob_sel = late_q[31:16];
      3'd7: prob_sel = late_q[47:32];
    endcase
  end

  // ---------------------------------------------------------------------
  // shared units
  // ---------------------------------------------------------------------
  secu_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  secu_addr #(
    .GRID_SIDE (GRID_SIDE)
  ) u_addr (
    .x_i      (x_q[CW-1:0]),
    .y_i      (y_q[CW-1:0]),
    .center_i (addr_center),
    .nb_idx_i (nb_idx_q),
    .addr_o   (gen_addr)
  );

  secu_ram #(
    .WIDTH (STATE_W),
    .DEPTH (CELLS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      nb_idx_q <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      nb_idx_q <= nb_idx_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    x_q    <= x_d;
    y_q    <= y_d;
    draw_q <= draw_d;
    wval_q <= wval_d;
    old_q  <= old_d;
    nxt_q  <= nxt_d;
    cnt_q  <= cnt_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    nb_idx_d    = nb_idx_q;
    pend_d      = pend_q;
    done_d      = 1'b0;
    op_d        = op_q;
    x_d         = x_q;
    y_d         = y_q;
    draw_d      = draw_q;
    wval_d      = wval_q;
    old_d       = old_q;
    nxt_d       = nxt_q;
    cnt_d       = cnt_q;
    alu_a       = ALU_W'(x_q);
    alu_b       = ALU_W'(GRID_SIDE);
    addr_center = 1'b1;
    ram_we      = 1'b0;
    ram_addr    = gen_addr;
    ram_wdata   = nxt_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = CELL_REST;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d    = operation_i;
          x_d     = XW'(col_x_i);
          y_d     = XW'(row_y_i);
          draw_d  = uniform_draw_i;
          wval_d  = write_value_i;
          state_d = ST_RED_X;
        end
      end
      // wrap coordinates by repeated subtraction of the side
      ST_RED_X: begin
        if (alu_res.lt) begin
          state_d = ST_RED_Y;
        end else begin
          x_d = alu_res.diff[XW-1:0];
        end
      end
      ST_RED_Y: begin
        alu_a = ALU_W'(y_q);
        if (alu_res.lt) begin
          state_d = ST_RD_C;
        end else begin
          y_d = alu_res.diff[XW-1:0];
        end
      end
      ST_RD_C: begin
        state_d = ST_DEC;
      end
      // center cell is on the read port now
      ST_DEC: begin
        alu_a    = ALU_W'(draw_q);
        alu_b    = ALU_W'(prob_sel);
        old_d    = ram_rdata;
        cnt_d    = '0;
        nb_idx_d = '0;
        pend_d   = 1'b0;
        if (op_q == OP_WRITE) begin
          nxt_d   = wval_q;
          state_d = ST_WR;
        end else if (ram_rdata == CELL_REST) begin
          nxt_d = CELL_REST;
          if (!alu_res.lt) begin
            state_d = ST_WR;
          end else if (n_eff == '0) begin
            state_d = ST_THR;
          end else begin
            state_d = ST_NB;
          end
        end else begin
          nxt_d   = alu_res.lt ? ram_rdata + STATE_W'(1) : ram_rdata;
          state_d = ST_WR;
        end
      end
      // one neighbor read per cycle, count the previous one
      ST_NB: begin
        addr_center = 1'b0;
        pend_d      = 1'b1;
        nb_idx_d    = nb_idx_q + NB_IDX_W'(1);
        if (pend_q && ram_rdata == CELL_EXCITED) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if ({1'b0, nb_idx_q} == n_eff - CNT_W'(1)) begin
          state_d = ST_NB_LAST;
        end
      end
      ST_NB_LAST: begin
        if (ram_rdata == CELL_EXCITED) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        state_d = ST_THR;
      end
      ST_THR: begin
        alu_a   = ALU_W'(cnt_q);
        alu_b   = ALU_W'(thr_q);
        nxt_d   = alu_res.lt ? CELL_REST : CELL_EXCITED;
        state_d = ST_WR;
      end
      ST_WR: begin
        ram_we  = 1'b1;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o              = (state_q != ST_IDLE);
  assign done_o              = done_q;
  assign old_state_o         = old_q;
  assign new_state_o         = nxt_q;
  assign excited_neighbors_o = cnt_q;
  assign changed_o           = (old_q != nxt_q);

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not make the unit busy");

  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_WR))
    else $error("grid written outside clear pass or write back");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_THR) |-> (cnt_q <= n_eff))
    else $error("neighbor count exceeds neighbors examined");

endmodule
